// ----- hw/rtl/cfsm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfsm_pkg
// Shared constants, lane types and helpers for the cube face to sphere map.
// ----------------------------------------------------------------------------
package cfsm_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int LANES       = 3;
    localparam int ROOT_STEPS  = 4;     // root iterations per stage
    localparam int ROOT_STAGES = 4;     // 16 result bits in total
    localparam int LATENCY     = 10;

    localparam logic signed [16:0] ONE_C = 17'sd16384;

    // floor(q / 3) = (q * DIV3_K) >> DIV3_SHIFT for q < 2^19
    localparam logic [18:0] DIV3_K     = 19'd349526;
    localparam int          DIV3_SHIFT = 20;

    localparam logic [2:0] FACE_XP = 3'd0;
    localparam logic [2:0] FACE_XN = 3'd1;
    localparam logic [2:0] FACE_YP = 3'd2;
    localparam logic [2:0] FACE_YN = 3'd3;
    localparam logic [2:0] FACE_ZP = 3'd4;
    localparam logic [2:0] FACE_ZN = 3'd5;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic [31:0] rad;
        logic [16:0] rem;
        logic [15:0] root;
    } t_lane;

    typedef struct packed {
        logic            vld;
        t_lane [2:0]     lane;
    } t_rbus;

    function automatic logic [1:0] oth_a(input logic [1:0] i);
        return (i == 2'd2) ? 2'd0 : 2'(i + 2'd1);
    endfunction

    function automatic logic [1:0] oth_b(input logic [1:0] i);
        return (i == 2'd0) ? 2'd2 : 2'(i - 2'd1);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cfsm_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfsm_front
// Face placement, squares, cross products, divide by three and root argument.
// Five register stages.
// ----------------------------------------------------------------------------
module cfsm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_vld,
    input  wire logic [2:0]         i_face,
    input  wire logic signed [15:0] i_coord_u,
    input  wire logic signed [15:0] i_coord_v,
    output cfsm_pkg::t_rbus         o_bus
);
    import cfsm_pkg::*;

    logic [4:0]  r_vld;

    logic        r1_neg [LANES];
    logic [15:0] r1_mag [LANES];
    logic        r2_neg [LANES];
    logic [15:0] r2_mag [LANES];
    logic [16:0] r2_sq  [LANES];
    logic        r3_neg [LANES];
    logic [15:0] r3_mag [LANES];
    logic [18:0] r3_pq  [LANES];
    logic [16:0] r3_hs  [LANES];
    logic        r4_neg [LANES];
    logic [15:0] r4_mag [LANES];
    logic [16:0] r4_d   [LANES];
    logic [16:0] r4_hs  [LANES];
    t_lane [2:0] r5_lane;

    logic signed [16:0] n_comp [LANES];
    logic signed [16:0] u17, v17;

    always_comb begin
        u17 = 17'(i_coord_u);
        v17 = 17'(i_coord_v);
        for (int i = 0; i < LANES; i++) begin
            n_comp[i] = '0;
        end
        unique case (i_face)
            FACE_XP: begin
                n_comp[0] = ONE_C;  n_comp[1] = v17;  n_comp[2] = -u17;
            end
            FACE_XN: begin
                n_comp[0] = -ONE_C; n_comp[1] = v17;  n_comp[2] = u17;
            end
            FACE_YP: begin
                n_comp[0] = u17;    n_comp[1] = ONE_C;  n_comp[2] = -v17;
            end
            FACE_YN: begin
                n_comp[0] = u17;    n_comp[1] = -ONE_C; n_comp[2] = v17;
            end
            FACE_ZP: begin
                n_comp[0] = u17;    n_comp[1] = v17;  n_comp[2] = ONE_C;
            end
            FACE_ZN: begin
                n_comp[0] = -u17;   n_comp[1] = v17;  n_comp[2] = -ONE_C;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] p2;
        logic [33:0] p3;
        logic [37:0] p4;
        logic signed [18:0] arg;
        logic [16:0] argc;
        for (int i = 0; i < LANES; i++) begin
            // stage 1: sign and magnitude
            r1_neg[i] <= n_comp[i][16];
            r1_mag[i] <= n_comp[i][16] ? 16'(-n_comp[i]) : 16'(n_comp[i]);
            // stage 2: square
            p2 = {16'b0, r1_mag[i]} * {16'b0, r1_mag[i]};
            r2_sq[i]  <= p2[30:FRAC_BITS];
            r2_neg[i] <= r1_neg[i];
            r2_mag[i] <= r1_mag[i];
            // stage 3: product of the other two squares, sum of halves
            p3 = {17'b0, r2_sq[oth_a(2'(i))]} * {17'b0, r2_sq[oth_b(2'(i))]};
            r3_pq[i]  <= p3[32:FRAC_BITS];
            r3_hs[i]  <= 17'(r2_sq[oth_a(2'(i))] >> 1) + 17'(r2_sq[oth_b(2'(i))] >> 1);
            r3_neg[i] <= r2_neg[i];
            r3_mag[i] <= r2_mag[i];
            // stage 4: divide by three
            p4 = {19'b0, r3_pq[i]} * {19'b0, DIV3_K};
            r4_d[i]   <= p4[DIV3_SHIFT+16:DIV3_SHIFT];
            r4_hs[i]  <= r3_hs[i];
            r4_neg[i] <= r3_neg[i];
            r4_mag[i] <= r3_mag[i];
            // stage 5: argument, clamp, root set-up
            arg = 19'(ONE_C) - $signed({2'b0, r4_hs[i]}) + $signed({2'b0, r4_d[i]});
            argc = arg[18] ? 17'd0 : arg[16:0];
            r5_lane[i].neg  <= r4_neg[i];
            r5_lane[i].mag  <= r4_mag[i];
            r5_lane[i].rad  <= {1'b0, argc, {FRAC_BITS{1'b0}}};
            r5_lane[i].rem  <= '0;
            r5_lane[i].root <= '0;
        end
    end

    assign o_bus.vld  = r_vld[4];
    assign o_bus.lane = r5_lane;

endmodule
`default_nettype wire

// ----- hw/rtl/cfsm_root_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfsm_root_stage
// Four restoring square root iterations on each of the three lanes.
// ----------------------------------------------------------------------------
module cfsm_root_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  cfsm_pkg::t_rbus i_bus,
    output cfsm_pkg::t_rbus o_bus
);
    import cfsm_pkg::*;

    logic        r_vld;
    t_lane [2:0] r_lane;
    t_lane [2:0] n_lane;

    always_comb begin
        logic [18:0] cur;
        logic [18:0] trial;
        n_lane = i_bus.lane;
        for (int i = 0; i < LANES; i++) begin
            for (int s = 0; s < ROOT_STEPS; s++) begin
                cur   = {n_lane[i].rem, n_lane[i].rad[31:30]};
                trial = {1'b0, n_lane[i].root, 2'b01};
                n_lane[i].rad = {n_lane[i].rad[29:0], 2'b00};
                if (cur >= trial) begin
                    n_lane[i].rem  = 17'(cur - trial);
                    n_lane[i].root = {n_lane[i].root[14:0], 1'b1};
                end else begin
                    n_lane[i].rem  = cur[16:0];
                    n_lane[i].root = {n_lane[i].root[14:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_bus.vld  = r_vld;
    assign o_bus.lane = r_lane;

endmodule
`default_nettype wire

// ----- hw/rtl/cfsm_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfsm_scale
// Scales each component by its root, restores the sign and saturates.
// ----------------------------------------------------------------------------
module cfsm_scale (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  cfsm_pkg::t_rbus         i_bus,
    output logic                    o_valid,
    output logic signed [15:0]      o_sphere_x,
    output logic signed [15:0]      o_sphere_y,
    output logic signed [15:0]      o_sphere_z
);
    import cfsm_pkg::*;

    logic        r_vld;
    logic [15:0] r_res [LANES];
    logic [15:0] n_res [LANES];

    always_comb begin
        logic [31:0] p;
        logic [17:0] r;
        for (int i = 0; i < LANES; i++) begin
            p = {16'b0, i_bus.lane[i].mag} * {16'b0, i_bus.lane[i].root};
            r = p[31:FRAC_BITS];
            if (!i_bus.lane[i].neg) begin
                n_res[i] = (r > 18'd32767) ? 16'h7fff : r[15:0];
            end else begin
                n_res[i] = (r >= 18'd32768) ? 16'h8000 : 16'(-r[15:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_bus.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid    = r_vld;
    assign o_sphere_x = r_res[0];
    assign o_sphere_y = r_res[1];
    assign o_sphere_z = r_res[2];

endmodule
`default_nettype wire

// ----- hw/rtl/cube_face_to_sphere_map.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cube_face_to_sphere_map
// Maps a point on a cube face onto the unit sphere, 14 fraction bits.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start, busy          i_face, i_coord_u, i_coord_v
//  result    o_valid (strobe)     o_sphere_x, o_sphere_y, o_sphere_z
//
//  One item per cycle; busy is never raised.
//  The 16-bit square root is computed four iterations per stage.
//  Synchronous active-low reset clears the valid bits only.
//  No stalls: each result shows for one cycle.
// ----------------------------------------------------------------------------
module cube_face_to_sphere_map (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_face,
    input  wire logic signed [15:0] i_coord_u,
    input  wire logic signed [15:0] i_coord_v,
    output logic                    o_valid,
    output logic signed [15:0]      o_sphere_x,
    output logic signed [15:0]      o_sphere_y,
    output logic signed [15:0]      o_sphere_z
);
    import cfsm_pkg::*;

    t_rbus bus [ROOT_STAGES+1];

    assign busy = 1'b0;

    cfsm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (start),
        .i_face    (i_face),
        .i_coord_u (i_coord_u),
        .i_coord_v (i_coord_v),
        .o_bus     (bus[0])
    );

    for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
        cfsm_root_stage u_root (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_bus   (bus[g]),
            .o_bus   (bus[g+1])
        );
    end

    cfsm_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bus      (bus[ROOT_STAGES]),
        .o_valid    (o_valid),
        .o_sphere_x (o_sphere_x),
        .o_sphere_y (o_sphere_y),
        .o_sphere_z (o_sphere_z)
    );

    a_item_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##10 o_valid)
        else $error("accepted item did not appear after pipeline latency");

    a_no_phantom : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##10 !o_valid)
        else $error("result strobe without an accepted item");

    a_zero_face : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_face[2] && i_face[1]) |->
            ##10 (o_sphere_x == 16'sd0 && o_sphere_y == 16'sd0 && o_sphere_z == 16'sd0))
        else $error("unused face gave non-zero point");

endmodule
`default_nettype wire

// ----- sim/cube_face_to_sphere_map_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_face_to_sphere_map_chk
// Watches the item and result channels, predicts each mapped point and
// compares it field by field with the block's result, oldest first.
// ----------------------------------------------------------------------------
module cube_face_to_sphere_map_chk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic [2:0]         i_face,
    input  wire logic signed [15:0] i_coord_u,
    input  wire logic signed [15:0] i_coord_v,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_sphere_x,
    input  wire logic signed [15:0] i_sphere_y,
    input  wire logic signed [15:0] i_sphere_z,
    output int                      o_fails,
    output int                      o_pending
);
    import cfsm_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_point;

    t_point points_q[$];

    function automatic longint root_floor(input longint n);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    function automatic longint sq_fx(input longint a);
        longint m;
        m = (a < 0) ? -a : a;
        return (m * m) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [15:0] scale_fx(input longint c, input longint a2,
                                                    input longint b2);
        longint arg, rt, m, s;
        arg = (longint'(1) << FRAC_BITS) - (a2 >>> 1) - (b2 >>> 1)
              + (((a2 * b2) >>> FRAC_BITS) / 3);
        if (arg < 0) arg = 0;
        rt = root_floor(arg << FRAC_BITS);
        m = (c < 0) ? -c : c;
        s = (m * rt) >>> FRAC_BITS;
        if (c < 0) s = -s;
        if (s < -32768) s = -32768;
        if (s > 32767) s = 32767;
        return 16'(s);
    endfunction

    function automatic t_point map_point(input logic [2:0] f, input longint u,
                                         input longint v);
        longint one, x, y, z, x2, y2, z2;
        t_point p;
        one = longint'(1) << FRAC_BITS;
        x = 0; y = 0; z = 0;
        case (f)
            FACE_XP: begin x = one;  y = v;    z = -u;   end
            FACE_XN: begin x = -one; y = v;    z = u;    end
            FACE_YP: begin x = u;    y = one;  z = -v;   end
            FACE_YN: begin x = u;    y = -one; z = v;    end
            FACE_ZP: begin x = u;    y = v;    z = one;  end
            FACE_ZN: begin x = -u;   y = v;    z = -one; end
            default: ;
        endcase
        x2 = sq_fx(x); y2 = sq_fx(y); z2 = sq_fx(z);
        p.x = scale_fx(x, y2, z2);
        p.y = scale_fx(y, z2, x2);
        p.z = scale_fx(z, x2, y2);
        return p;
    endfunction

    assign o_pending = points_q.size();

    always @(posedge i_clk) begin
        t_point e;
        int     nf;
        nf = 0;
        if (i_rst_n && i_valid) begin
            if (points_q.size() == 0) begin
                $error("result with no item pending");
                nf++;
            end else begin
                e = points_q.pop_front();
                if (e.x !== i_sphere_x) begin
                    $error("sphere_x exp %0d got %0d", e.x, i_sphere_x);
                    nf++;
                end
                if (e.y !== i_sphere_y) begin
                    $error("sphere_y exp %0d got %0d", e.y, i_sphere_y);
                    nf++;
                end
                if (e.z !== i_sphere_z) begin
                    $error("sphere_z exp %0d got %0d", e.z, i_sphere_z);
                    nf++;
                end
            end
        end
        if (nf != 0)
            o_fails <= o_fails + nf;
        if (i_rst_n && i_start && !i_busy)
            points_q.push_back(map_point(i_face, longint'(i_coord_u), longint'(i_coord_v)));
    end
endmodule

// ----- sim/cube_face_to_sphere_map_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_face_to_sphere_map_tb
// Drives directed and random items into the sphere map with random gaps;
// the checker predicts and compares, this top gives the verdict.
// ----------------------------------------------------------------------------
module cube_face_to_sphere_map_tb;
    import cfsm_pkg::*;

    localparam int WATCHDOG = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_face = '0;
    logic signed [15:0] i_coord_u = '0;
    logic signed [15:0] i_coord_v = '0;
    logic               o_valid;
    logic signed [15:0] o_sphere_x, o_sphere_y, o_sphere_z;
    int                 fails, pending, idle_cycles;

    always #5 i_clk = ~i_clk;

    cube_face_to_sphere_map dut (.*);

    cube_face_to_sphere_map_chk chk (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_face,
        .i_coord_u, .i_coord_v, .i_valid(o_valid), .i_sphere_x(o_sphere_x),
        .i_sphere_y(o_sphere_y), .i_sphere_z(o_sphere_z),
        .o_fails(fails), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] f, input logic [15:0] u,
                             input logic [15:0] v, input bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 9) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start <= 1'b1;
        i_face <= f;
        i_coord_u <= u;
        i_coord_v <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'(-16384);
            2:       return 16'(16384);
            default: return 16'($signed($urandom_range(32768)) - 16384);
        endcase
    endfunction

    initial begin
        logic [15:0] edges [6];
        edges = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 16'h2D41};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int f = 0; f < 8; f++)
            send_item(3'(f), edges[f % 6], edges[(f + 3) % 6], 1'b0);
        for (int k = 0; k < 12; k++)
            send_item(3'(k % 6), edges[k % 6], edges[(k * 5 + 1) % 6], 1'b0);
        for (int n = 0; n < 1800; n++) begin
            send_item(3'($urandom_range(7)), rnd_coord(), rnd_coord(),
                      !(n >= 600 && n < 900));
            if (n == 1000) begin
                start <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
        if (fails == 0 && pending == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/cfsm_pkg.sv
hw/rtl/cfsm_front.sv
hw/rtl/cfsm_root_stage.sv
hw/rtl/cfsm_scale.sv
hw/rtl/cube_face_to_sphere_map.sv
sim/cube_face_to_sphere_map_chk.sv
sim/cube_face_to_sphere_map_tb.sv
